[design/tps_pkg.sv]
`timescale 1ns / 1ps
// tps_pkg: shared constants, field widths and codes for the tournament parent selector.
// Depends on nothing; used by the channel interfaces and tournament_parent_selector.
package tps_pkg;

  // default sizing of the top level
  localparam int POP_MAX_DEF     = 1024;
  localparam int SCORE_WIDTH_DEF = 32;

  // fixed field widths
  localparam int SLOT_W     = 10;  // population slot
  localparam int CNT_W      = 11;  // population / elitism / offspring count
  localparam int TSIZE_W    = 8;   // tournament size and draw counter
  localparam int IN_SCORE_W = 32;  // Q16.16 score on the request channel

  // configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [CNT_W-1:0]   POP_COUNT_RST  = CNT_W'(1024);
  localparam logic [CNT_W-1:0]   ELITISM_RST    = '0;
  localparam logic [TSIZE_W-1:0] TOURN_SIZE_RST = TSIZE_W'(2);

  typedef enum logic [1:0] {
    REG_POP_COUNT  = 2'd0,
    REG_ELITISM    = 2'd1,
    REG_TOURN_SIZE = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_DRAW = 1'b1
  } cmd_e;

endpackage

[design/tps_if.sv]
`timescale 1ns / 1ps
// tps_req_if / tps_rsp_if: valid/ready channels of the tournament parent selector.
// Depends on tps_pkg for field widths.
interface tps_req_if;
  import tps_pkg::*;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic signed [IN_SCORE_W-1:0] score;
  logic        [SLOT_W-1:0]     load_slot;
  logic        [SLOT_W-1:0]     random_slot;

  modport source (output valid, command, score, load_slot, random_slot, input ready);
  modport sink   (input valid, command, score, load_slot, random_slot, output ready);
endinterface

interface tps_rsp_if;
  import tps_pkg::*;
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] parent_slot;
  logic [SLOT_W-1:0] offspring_number;
  logic              generation_done;

  modport source (output valid, parent_slot, offspring_number, generation_done, input ready);
  modport sink   (input valid, parent_slot, offspring_number, generation_done, output ready);
endinterface

[design/tps_score_mem.sv]
`timescale 1ns / 1ps
// tps_score_mem: dual-port fitness score store, one write and one read per cycle.
// Read data is registered and holds until the next read.
module tps_score_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/tournament_parent_selector.sv]
`timescale 1ns / 1ps
// tournament_parent_selector: tournament selection with elitism over a stored score table.
// Depends on tps_pkg, tps_req_if / tps_rsp_if and tps_score_mem.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+---------------------------------------------
//  req_i   | in  | valid/ready           | command, score, load_slot, random_slot
//  rsp_o   | out | valid/ready           | parent_slot, offspring_number, generation_done
//  apb     | in  | psel/penable, pready  | paddr, pwdata (write), prdata (read)
//
// One request per cycle sustained. A request enters at acceptance, where loads write the
// score store and draws issue their read; when it moves on, the decision stage uses the
// registered read data and updates best/winner/counters, filling the output register.
// A load followed by a draw of the same slot needs no forwarding: the write lands first.
// Reset is asynchronous, active low; the score store is not cleared.
// The decision stage moves only when the output register is empty or being drained, so
// a stalled result backs up into req_i.ready through one held request.
module tournament_parent_selector #(
  parameter int POP_MAX     = tps_pkg::POP_MAX_DEF,
  parameter int SCORE_WIDTH = tps_pkg::SCORE_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  tps_req_if.sink                      req_i,
  tps_rsp_if.source                    rsp_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tps_pkg::PADDR_W-1:0]  paddr,
  input  logic [tps_pkg::PDATA_W-1:0]  pwdata,
  output logic [tps_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  import tps_pkg::*;

  localparam int AW = $clog2(POP_MAX);
  localparam int PW = $clog2(POP_MAX + 1);
  // compare width: wide enough for POP_MAX and any 11-bit count
  localparam int CW = (PW > CNT_W) ? PW : CNT_W;

  // ---------------- configuration registers ----------------
  logic [CNT_W-1:0]   pop_cfg_q;
  logic [CNT_W-1:0]   elit_cfg_q;
  logic [TSIZE_W-1:0] tsize_cfg_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_cfg_q   <= POP_COUNT_RST;
      elit_cfg_q  <= ELITISM_RST;
      tsize_cfg_q <= TOURN_SIZE_RST;
    end else if (cfg_wr) begin
      case (cfg_reg_e'(paddr[3:2]))
        REG_POP_COUNT:  pop_cfg_q   <= pwdata[CNT_W-1:0];
        REG_ELITISM:    elit_cfg_q  <= pwdata[CNT_W-1:0];
        REG_TOURN_SIZE: tsize_cfg_q <= pwdata[TSIZE_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_e'(paddr[3:2]))
      REG_POP_COUNT:  prdata = PDATA_W'(pop_cfg_q);
      REG_ELITISM:    prdata = PDATA_W'(elit_cfg_q);
      REG_TOURN_SIZE: prdata = PDATA_W'(tsize_cfg_q);
      default:        prdata = '0;
    endcase
  end

  // effective population: count clipped to store depth
  logic [CW-1:0]      pop_eff;
  logic [TSIZE_W-1:0] tsize_eff;

  assign pop_eff   = (CW'(pop_cfg_q) > CW'(POP_MAX)) ? CW'(POP_MAX) : CW'(pop_cfg_q);
  assign tsize_eff = (tsize_cfg_q == '0) ? TSIZE_W'(1) : tsize_cfg_q;

  // ---------------- accept stage: store access ----------------
  logic                          in_acc;
  logic                          s1_go;
  logic                          mem_we;
  logic                          mem_re;
  logic signed [SCORE_WIDTH-1:0] in_score;
  logic        [SCORE_WIDTH-1:0] mem_rdata;

  assign in_acc   = req_i.valid && req_i.ready;
  // size cast sign-extends or truncates the Q16.16 score to the store width
  assign in_score = SCORE_WIDTH'(req_i.score);
  assign mem_we   = in_acc && (cmd_e'(req_i.command) == CMD_LOAD)
                    && (CW'(req_i.load_slot) < pop_eff);
  assign mem_re   = in_acc && (cmd_e'(req_i.command) == CMD_DRAW);

  tps_score_mem #(
    .DEPTH (POP_MAX),
    .WIDTH (SCORE_WIDTH)
  ) u_score_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AW'(req_i.load_slot)),
    .wdata_i (in_score),
    .re_i    (mem_re),
    .raddr_i (AW'(req_i.random_slot)),
    .rdata_o (mem_rdata)
  );

  // held request for the decision stage
  logic                          s1_valid_q;
  logic                          s1_cmd_q;
  logic signed [SCORE_WIDTH-1:0] s1_score_q;
  logic        [SLOT_W-1:0]      s1_lslot_q;
  logic        [SLOT_W-1:0]      s1_rslot_q;

  assign req_i.ready = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q   <= req_i.command;
      s1_score_q <= in_score;
      s1_lslot_q <= req_i.load_slot;
      s1_rslot_q <= req_i.random_slot;
    end
  end

  // ---------------- decision stage ----------------
  logic        [SLOT_W-1:0]      best_slot_q, best_slot_d;
  logic signed [SCORE_WIDTH-1:0] best_score_q, best_score_d;
  logic        [SLOT_W-1:0]      win_slot_q, win_slot_d;
  logic signed [SCORE_WIDTH-1:0] win_score_q, win_score_d;
  logic        [TSIZE_W-1:0]     draws_q, draws_d, draws_inc;
  logic        [CNT_W-1:0]       off_q, off_d, off_inc;
  logic                          emit;
  logic        [SLOT_W-1:0]      emit_slot;
  logic signed [SCORE_WIDTH-1:0] rd_score;

  logic              out_valid_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic [SLOT_W-1:0] out_num_q;
  logic              out_done_q;

  assign s1_go     = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign rd_score  = mem_rdata;
  assign off_inc   = off_q + CNT_W'(1);
  assign draws_inc = draws_q + TSIZE_W'(1);

  always_comb begin
    best_slot_d  = best_slot_q;
    best_score_d = best_score_q;
    win_slot_d   = win_slot_q;
    win_score_d  = win_score_q;
    draws_d      = draws_q;
    off_d        = off_q;
    emit         = 1'b0;
    emit_slot    = best_slot_q;

    if (cmd_e'(s1_cmd_q) == CMD_LOAD) begin
      if (CW'(s1_lslot_q) < pop_eff) begin
        if (s1_lslot_q == '0) begin
          // slot 0 opens a new generation
          best_slot_d  = '0;
          best_score_d = s1_score_q;
          off_d        = '0;
          draws_d      = '0;
        end else if (s1_score_q > best_score_q) begin
          best_slot_d  = s1_lslot_q;
          best_score_d = s1_score_q;
        end
      end
    end else if (CW'(off_q) < pop_eff) begin
      if (off_q < elit_cfg_q) begin
        // elitist pick, random slot unused
        emit      = 1'b1;
        emit_slot = best_slot_q;
      end else if (CW'(s1_rslot_q) < pop_eff) begin
        if ((draws_q == '0) || (rd_score > win_score_q)) begin
          win_slot_d  = s1_rslot_q;
          win_score_d = rd_score;
        end
        // round ends at the size, or when the draw counter wraps
        if ((draws_inc >= tsize_eff) || (draws_inc == '0)) begin
          draws_d   = '0;
          emit      = 1'b1;
          emit_slot = win_slot_d;
        end else begin
          draws_d = draws_inc;
        end
      end
    end

    if (emit) begin
      off_d = off_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_slot_q  <= '0;
      best_score_q <= '0;
      win_slot_q   <= '0;
      win_score_q  <= '0;
      draws_q      <= '0;
      off_q        <= '0;
    end else if (s1_go) begin
      best_slot_q  <= best_slot_d;
      best_score_q <= best_score_d;
      win_slot_q   <= win_slot_d;
      win_score_q  <= win_score_d;
      draws_q      <= draws_d;
      off_q        <= off_d;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && emit) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && emit) begin
      out_slot_q <= emit_slot;
      out_num_q  <= off_q[SLOT_W-1:0];
      out_done_q <= (CW'(off_inc) >= pop_eff);
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.parent_slot      = out_slot_q;
  assign rsp_o.offspring_number = out_num_q;
  assign rsp_o.generation_done  = out_done_q;

endmodule
